### design/first_fit_lease_allocator_macros.svh
// Assertion macros for the first-fit lease allocator.
// In synthesis builds every macro expands to nothing.
`ifndef FIRST_FIT_LEASE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_LEASE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define FFLA_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator invariant violated");
// When the antecedent holds, the consequent holds in the next cycle.
`define FFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator next-cycle check failed");
`else
`define FFLA_ASSERT_HOLDS(label, clk, rst_n, cond)
`define FFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/ffla_pkg.sv
`default_nettype none

package ffla_pkg;

    // Fixed field widths.
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned OUT_ADDR_W = 16;
    localparam int unsigned CNT_W      = 7;

    // Request codes. The last code is not a defined request and changes nothing.
    typedef logic [1:0] t_req;
    localparam t_req REQ_ALLOC  = 2'd0;
    localparam t_req REQ_EXPIRE = 2'd1;
    localparam t_req REQ_MERGE  = 2'd2;
    localparam t_req REQ_NONE   = 2'd3;

    // Status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_ALLOC = 3'd0;
    localparam t_status ST_NOFIT = 3'd1;
    localparam t_status ST_LFULL = 3'd2;
    localparam t_status ST_DONE  = 3'd3;
    localparam t_status ST_OVFL  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        t_req              req_type;
        logic [LEN_W-1:0]  block_size;
        logic [TIME_W-1:0] current_time;
        logic [DUR_W-1:0]  lease_duration;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [OUT_ADDR_W-1:0] start_address;
        logic [CNT_W-1:0]      event_count;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_INIT     = 13'b0000000000010,
        S_AL_CHK   = 13'b0000000000100,
        S_RM       = 13'b0000000001000,
        S_EX_CHK   = 13'b0000000010000,
        S_EX_NXT   = 13'b0000000100000,
        S_IN_RD    = 13'b0000001000000,
        S_IN_CHK   = 13'b0000010000000,
        S_MG_FIRST = 13'b0000100000000,
        S_MG_CHK   = 13'b0001000000000,
        S_MG_END   = 13'b0010000000000,
        S_DONE     = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } t_state;

endpackage

`default_nettype wire

### design/first_fit_lease_allocator.sv
// First-fit lease allocator.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one request:
// allocate, expire leases due, or merge adjacent free blocks. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns exactly one result per
// request. A request is taken only while the sequencer is idle; it then walks
// the free list or the lease table one entry per cycle through memories with
// registered reads, pausing the lease walk while a returned lease is inserted.
// Allocate scans for the first fit and shifts entries down when a block is
// used up; expire inserts each returned lease in order; merge walks the free
// list. The result register lets the next request enter while a result waits.
// Writing i_cfg_wr_data with i_cfg_wr_en (only while idle) sets the pool size,
// drops all leases and leaves one free block at address 0. Reset does the same
// with the largest pool, then writes the first free entry before the first
// request is taken. While the receiver stalls, the result holds; a finished
// request waits until the register frees.
`default_nettype none
`include "first_fit_lease_allocator_macros.svh"

module first_fit_lease_allocator #(
    parameter int unsigned FREE_SLOTS  = 64,
    parameter int unsigned LEASE_SLOTS = 64,
    parameter int unsigned ADDR_BITS   = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire ffla_pkg::t_in_item           i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output ffla_pkg::t_out_item               o_out_data,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [ffla_pkg::LEN_W-1:0]   i_cfg_wr_data
);

    localparam int unsigned LEN_W = ffla_pkg::LEN_W;
    localparam int unsigned FI_W  = $clog2(FREE_SLOTS);
    localparam int unsigned FC_W  = $clog2(FREE_SLOTS + 1);
    localparam int unsigned LI_W  = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
    localparam int unsigned LC_W  = $clog2(LEASE_SLOTS + 1);
    localparam int unsigned SUM_W = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

    localparam logic [SUM_W-1:0] MAX_POOL  = {{(SUM_W-1){1'b0}}, 1'b1} << ADDR_BITS;
    localparam logic [SUM_W-1:0] CAP_POOL  = SUM_W'(65536);
    localparam logic [SUM_W-1:0] RST_POOLW = (MAX_POOL > CAP_POOL) ? CAP_POOL : MAX_POOL;
    localparam logic [LEN_W-1:0] RST_POOL  = RST_POOLW[LEN_W-1:0];
    localparam logic [FC_W-1:0]  FREE_FULL  = FC_W'(FREE_SLOTS);
    localparam logic [LC_W-1:0]  LEASE_FULL = LC_W'(LEASE_SLOTS);

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
    } t_free_ent;

    typedef struct packed {
        logic [ADDR_BITS-1:0]           start;
        logic [LEN_W-1:0]               len;
        logic [ffla_pkg::TIME_W-1:0]    expiry;
    } t_lease_ent;

    // Storage.
    t_free_ent  r_free_mem  [FREE_SLOTS];
    t_lease_ent r_lease_mem [LEASE_SLOTS];
    t_free_ent  r_frd;
    t_lease_ent r_lrd;

    // Memory port controls.
    logic       f_we;
    logic [FI_W-1:0] f_waddr, f_raddr;
    t_free_ent  f_wdata;
    logic       l_we;
    logic [LI_W-1:0] l_waddr, l_raddr;
    t_lease_ent l_wdata;

    // Control and working registers.
    ffla_pkg::t_state r_state, n_state;
    logic [LEN_W-1:0] r_pool, n_pool;
    logic [FC_W-1:0]  r_free_cnt, n_free_cnt;
    logic [LC_W-1:0]  r_lease_cnt, n_lease_cnt;
    logic             r_out_valid, n_out_valid;
    ffla_pkg::t_out_item r_out, n_out;
    logic [LEN_W-1:0] r_bsize, n_bsize;
    logic [ffla_pkg::TIME_W-1:0] r_now, n_now, r_exp, n_exp;
    logic [FI_W-1:0]  r_fi, n_fi;
    logic [FI_W-1:0]  r_wp, n_wp;
    logic [FI_W-1:0]  r_k, n_k;
    logic [LC_W-1:0]  r_li, n_li;
    logic [LC_W-1:0]  r_keep, n_keep;
    t_free_ent        r_cur, n_cur;
    t_free_ent        r_ins, n_ins;
    logic [ffla_pkg::CNT_W-1:0] r_count, n_count;
    logic             r_ovfl, n_ovfl;
    ffla_pkg::t_status r_status, n_status;
    logic [ADDR_BITS-1:0] r_addr, n_addr;

    // Helper values.
    logic             accept;
    logic             load_result;
    logic [ffla_pkg::TIME_W:0] exp_sum;
    logic [FC_W:0]    fi_p1, fi_p2, free_cnt_x;
    logic [LC_W:0]    li_p1, lease_cnt_x;
    logic [ffla_pkg::CNT_W-1:0] count_inc;
    logic [SUM_W-1:0] cur_end;
    logic [SUM_W-1:0] cfg_w;
    logic [LEN_W-1:0] cfg_pool;
    logic             due;

    assign o_in_stall  = (r_state != ffla_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign load_result = (r_state == ffla_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    assign exp_sum     = {1'b0, i_in_data.current_time} +
                         (ffla_pkg::TIME_W + 1)'(i_in_data.lease_duration);
    assign fi_p1       = (FC_W + 1)'(r_fi) + (FC_W + 1)'(1);
    assign fi_p2       = (FC_W + 1)'(r_fi) + (FC_W + 1)'(2);
    assign free_cnt_x  = (FC_W + 1)'(r_free_cnt);
    assign li_p1       = (LC_W + 1)'(r_li) + (LC_W + 1)'(1);
    assign lease_cnt_x = (LC_W + 1)'(r_lease_cnt);
    assign count_inc   = (r_count == ffla_pkg::CNT_MAX) ? r_count : r_count + 1'b1;
    assign cur_end     = SUM_W'(r_cur.start) + SUM_W'(r_cur.len);
    assign due         = (r_lrd.expiry <= r_now);
    assign cfg_w       = SUM_W'(i_cfg_wr_data);

    // Pool size clamp: zero becomes one, oversize becomes the address span.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_pool = LEN_W'(1);
        end else if (cfg_w > MAX_POOL) begin
            cfg_pool = MAX_POOL[LEN_W-1:0];
        end else begin
            cfg_pool = i_cfg_wr_data;
        end
    end

    // Sequencer and next-state datapath.
    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_free_cnt  = r_free_cnt;
        n_lease_cnt = r_lease_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_bsize     = r_bsize;
        n_now       = r_now;
        n_exp       = r_exp;
        n_fi        = r_fi;
        n_wp        = r_wp;
        n_k         = r_k;
        n_li        = r_li;
        n_keep      = r_keep;
        n_cur       = r_cur;
        n_ins       = r_ins;
        n_count     = r_count;
        n_ovfl      = r_ovfl;
        n_status    = r_status;
        n_addr      = r_addr;
        f_we        = 1'b0;
        f_waddr     = '0;
        f_wdata     = '0;
        f_raddr     = '0;
        l_we        = 1'b0;
        l_waddr     = '0;
        l_wdata     = '0;
        l_raddr     = '0;

        // A waiting result leaves on a transfer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ffla_pkg::S_IDLE: begin
                // Entry 0 of both memories is read here, ready for the first step.
                if (accept) begin
                    n_bsize  = i_in_data.block_size;
                    n_now    = i_in_data.current_time;
                    n_exp    = exp_sum[ffla_pkg::TIME_W] ? '1 :
                               exp_sum[ffla_pkg::TIME_W-1:0];
                    n_count  = '0;
                    n_ovfl   = 1'b0;
                    n_addr   = '0;
                    n_status = ffla_pkg::ST_DONE;
                    n_fi     = '0;
                    n_li     = '0;
                    n_keep   = '0;
                    n_wp     = '0;
                    n_state  = ffla_pkg::S_DONE;
                    case (i_in_data.req_type)
                        ffla_pkg::REQ_ALLOC: begin
                            if (r_lease_cnt >= LEASE_FULL) begin
                                n_status = ffla_pkg::ST_LFULL;
                            end else begin
                                n_status = ffla_pkg::ST_NOFIT;
                                if (i_in_data.block_size != '0 && r_free_cnt != '0) begin
                                    n_state = ffla_pkg::S_AL_CHK;
                                end
                            end
                        end
                        ffla_pkg::REQ_EXPIRE: begin
                            if (r_lease_cnt != '0) begin
                                n_state = ffla_pkg::S_EX_CHK;
                            end
                        end
                        ffla_pkg::REQ_MERGE: begin
                            if (r_free_cnt > FC_W'(1)) begin
                                n_state = ffla_pkg::S_MG_FIRST;
                            end
                        end
                        default: begin
                            n_state = ffla_pkg::S_DONE;
                        end
                    endcase
                end
            end

            ffla_pkg::S_INIT: begin
                // One free block covering the whole pool.
                f_we    = 1'b1;
                f_waddr = '0;
                f_wdata = '{start: '0, len: r_pool};
                n_state = ffla_pkg::S_IDLE;
            end

            ffla_pkg::S_AL_CHK: begin
                // First-fit scan, one free entry per cycle.
                if (r_frd.len >= r_bsize) begin
                    l_we        = 1'b1;
                    l_waddr     = r_lease_cnt[LI_W-1:0];
                    l_wdata     = '{start: r_frd.start, len: r_bsize, expiry: r_exp};
                    n_lease_cnt = r_lease_cnt + 1'b1;
                    n_status    = ffla_pkg::ST_ALLOC;
                    n_addr      = r_frd.start;
                    if (r_frd.len > r_bsize) begin
                        f_we    = 1'b1;
                        f_waddr = r_fi;
                        f_wdata = '{start: r_frd.start + ADDR_BITS'(r_bsize),
                                    len: r_frd.len - r_bsize};
                        n_state = ffla_pkg::S_DONE;
                    end else if (fi_p1 < free_cnt_x) begin
                        f_raddr = fi_p1[FI_W-1:0];
                        n_state = ffla_pkg::S_RM;
                    end else begin
                        n_free_cnt = r_free_cnt - 1'b1;
                        n_state    = ffla_pkg::S_DONE;
                    end
                end else if (fi_p1 < free_cnt_x) begin
                    f_raddr = fi_p1[FI_W-1:0];
                    n_fi    = fi_p1[FI_W-1:0];
                end else begin
                    n_state = ffla_pkg::S_DONE;
                end
            end

            ffla_pkg::S_RM: begin
                // Close the gap of a used-up block.
                f_we    = 1'b1;
                f_waddr = r_fi;
                f_wdata = r_frd;
                if (fi_p2 < free_cnt_x) begin
                    f_raddr = fi_p2[FI_W-1:0];
                    n_fi    = fi_p1[FI_W-1:0];
                end else begin
                    n_free_cnt = r_free_cnt - 1'b1;
                    n_state    = ffla_pkg::S_DONE;
                end
            end

            ffla_pkg::S_EX_CHK: begin
                // Each lease is either returned or compacted down to the keep slot.
                n_li = li_p1[LC_W-1:0];
                if (due && r_free_cnt < FREE_FULL) begin
                    n_ins   = '{start: r_lrd.start, len: r_lrd.len};
                    n_count = count_inc;
                    n_k     = r_free_cnt[FI_W-1:0];
                    n_state = ffla_pkg::S_IN_RD;
                end else begin
                    l_we    = 1'b1;
                    l_waddr = r_keep[LI_W-1:0];
                    l_wdata = r_lrd;
                    n_keep  = r_keep + 1'b1;
                    if (due) begin
                        n_ovfl = 1'b1;
                    end
                    if (li_p1 < lease_cnt_x) begin
                        l_raddr = li_p1[LI_W-1:0];
                    end else begin
                        n_lease_cnt = r_keep + 1'b1;
                        n_status    = (due || r_ovfl) ? ffla_pkg::ST_OVFL :
                                                        ffla_pkg::ST_DONE;
                        n_state     = ffla_pkg::S_DONE;
                    end
                end
            end

            ffla_pkg::S_EX_NXT: begin
                // Resume the lease walk after an insert.
                if (r_li < r_lease_cnt) begin
                    l_raddr = r_li[LI_W-1:0];
                    n_state = ffla_pkg::S_EX_CHK;
                end else begin
                    n_lease_cnt = r_keep;
                    n_status    = r_ovfl ? ffla_pkg::ST_OVFL : ffla_pkg::ST_DONE;
                    n_state     = ffla_pkg::S_DONE;
                end
            end

            ffla_pkg::S_IN_RD: begin
                // Sorted insert, walking down from the top of the list.
                if (r_k == '0) begin
                    f_we       = 1'b1;
                    f_waddr    = '0;
                    f_wdata    = r_ins;
                    n_free_cnt = r_free_cnt + 1'b1;
                    n_state    = ffla_pkg::S_EX_NXT;
                end else begin
                    f_raddr = r_k - 1'b1;
                    n_state = ffla_pkg::S_IN_CHK;
                end
            end

            ffla_pkg::S_IN_CHK: begin
                f_we    = 1'b1;
                f_waddr = r_k;
                if (r_frd.start >= r_ins.start) begin
                    f_wdata = r_frd;
                    n_k     = r_k - 1'b1;
                    if (r_k > FI_W'(1)) begin
                        f_raddr = r_k - FI_W'(2);
                    end else begin
                        n_state = ffla_pkg::S_IN_RD;
                    end
                end else begin
                    f_wdata    = r_ins;
                    n_free_cnt = r_free_cnt + 1'b1;
                    n_state    = ffla_pkg::S_EX_NXT;
                end
            end

            ffla_pkg::S_MG_FIRST: begin
                n_cur   = r_frd;
                f_raddr = FI_W'(1);
                n_fi    = FI_W'(1);
                n_state = ffla_pkg::S_MG_CHK;
            end

            ffla_pkg::S_MG_CHK: begin
                // Grow the current block or flush it to the write pointer.
                if (cur_end == SUM_W'(r_frd.start)) begin
                    n_cur.len = r_cur.len + r_frd.len;
                    n_count   = count_inc;
                end else begin
                    f_we    = 1'b1;
                    f_waddr = r_wp;
                    f_wdata = r_cur;
                    n_wp    = r_wp + 1'b1;
                    n_cur   = r_frd;
                end
                if (fi_p1 < free_cnt_x) begin
                    f_raddr = fi_p1[FI_W-1:0];
                    n_fi    = fi_p1[FI_W-1:0];
                end else begin
                    n_state = ffla_pkg::S_MG_END;
                end
            end

            ffla_pkg::S_MG_END: begin
                f_we       = 1'b1;
                f_waddr    = r_wp;
                f_wdata    = r_cur;
                n_free_cnt = FC_W'(r_wp) + 1'b1;
                n_state    = ffla_pkg::S_DONE;
            end

            ffla_pkg::S_DONE: begin
                // Load the result register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status,
                                    start_address: ffla_pkg::OUT_ADDR_W'(r_addr),
                                    event_count: r_count};
                    n_state     = ffla_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ffla_pkg::S_IDLE;
            end
        endcase

        // A pool size write restarts the pool.
        if (i_cfg_wr_en) begin
            n_pool      = cfg_pool;
            n_free_cnt  = FC_W'(1);
            n_lease_cnt = '0;
            n_state     = ffla_pkg::S_INIT;
        end
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_free_mem[f_waddr] <= f_wdata;
        end
        r_frd <= r_free_mem[f_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lease_mem[l_waddr] <= l_wdata;
        end
        r_lrd <= r_lease_mem[l_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffla_pkg::S_INIT;
            r_pool      <= RST_POOL;
            r_free_cnt  <= FC_W'(1);
            r_lease_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool      <= n_pool;
            r_free_cnt  <= n_free_cnt;
            r_lease_cnt <= n_lease_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_bsize  <= n_bsize;
        r_now    <= n_now;
        r_exp    <= n_exp;
        r_fi     <= n_fi;
        r_wp     <= n_wp;
        r_k      <= n_k;
        r_li     <= n_li;
        r_keep   <= n_keep;
        r_cur    <= n_cur;
        r_ins    <= n_ins;
        r_count  <= n_count;
        r_ovfl   <= n_ovfl;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    // Checks.
    `FFLA_ASSERT_HOLDS(a_free_cnt_bound, i_clk, i_rst_n, r_free_cnt <= FREE_FULL)
    `FFLA_ASSERT_HOLDS(a_lease_cnt_bound, i_clk, i_rst_n, r_lease_cnt <= LEASE_FULL)
    `FFLA_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, load_result, o_out_valid)

endmodule

`default_nettype wire

### test/first_fit_lease_allocator_tb.sv
`default_nettype none

module first_fit_lease_allocator_tb;

    localparam int unsigned NFREE  = 64;
    localparam int unsigned NLEASE = 64;
    localparam int unsigned POOL_MAX = 65536;
    localparam int unsigned WATCHDOG_LIMIT = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    ffla_pkg::t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    ffla_pkg::t_out_item out_data;
    logic      cfg_wr_en;
    logic [ffla_pkg::LEN_W-1:0] cfg_wr_data;

    first_fit_lease_allocator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    // Pool state mirrored by the predictor.
    int unsigned pool_len;
    int unsigned fr_start[NFREE];
    int unsigned fr_len[NFREE];
    int unsigned fr_count;
    int unsigned ls_start[NLEASE];
    int unsigned ls_len[NLEASE];
    logic [31:0] ls_expiry[NLEASE];
    int unsigned ls_count;

    ffla_pkg::t_in_item  request_queue[$];
    ffla_pkg::t_out_item result_queue[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          hold_sender;
    bit          long_stall_req;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic void pool_reinit(int unsigned size);
        pool_len = size;
        fr_start[0] = 0;
        fr_len[0] = size;
        fr_count = 1;
        ls_count = 0;
    endfunction

    function automatic bit free_list_insert(int unsigned s, int unsigned len);
        int unsigned pos;
        pos = 0;
        if (fr_count >= NFREE) return 1'b0;
        while (pos < fr_count && fr_start[pos] < s) pos++;
        for (int unsigned i = fr_count; i > pos; i--) begin
            fr_start[i] = fr_start[i-1];
            fr_len[i] = fr_len[i-1];
        end
        fr_start[pos] = s;
        fr_len[pos] = len;
        fr_count++;
        return 1'b1;
    endfunction

    function automatic void free_list_remove(int unsigned pos);
        for (int unsigned i = pos; i + 1 < fr_count; i++) begin
            fr_start[i] = fr_start[i+1];
            fr_len[i] = fr_len[i+1];
        end
        fr_count--;
    endfunction

    // Compute the result of one request and update the mirrored pool.
    function automatic ffla_pkg::t_out_item allocator_predict(ffla_pkg::t_in_item rq);
        ffla_pkg::t_out_item r;
        int unsigned cnt;
        int unsigned keep;
        int unsigned i;
        bit ovfl;
        bit due;
        logic [32:0] exp_sum;
        r.status = ffla_pkg::ST_DONE;
        r.start_address = '0;
        cnt = 0;
        if (rq.req_type == ffla_pkg::REQ_ALLOC) begin
            r.status = ffla_pkg::ST_NOFIT;
            if (ls_count >= NLEASE) begin
                r.status = ffla_pkg::ST_LFULL;
            end else if (rq.block_size != 0) begin
                for (i = 0; i < fr_count; i++) begin
                    if (fr_len[i] >= rq.block_size) begin
                        exp_sum = {1'b0, rq.current_time} + 33'(rq.lease_duration);
                        r.start_address = fr_start[i][15:0];
                        ls_start[ls_count] = fr_start[i];
                        ls_len[ls_count] = 32'(rq.block_size);
                        ls_expiry[ls_count] = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
                        ls_count++;
                        if (fr_len[i] > rq.block_size) begin
                            fr_start[i] += 32'(rq.block_size);
                            fr_len[i] -= 32'(rq.block_size);
                        end else begin
                            free_list_remove(i);
                        end
                        r.status = ffla_pkg::ST_ALLOC;
                        break;
                    end
                end
            end
        end else if (rq.req_type == ffla_pkg::REQ_EXPIRE) begin
            keep = 0;
            ovfl = 1'b0;
            for (i = 0; i < ls_count; i++) begin
                due = ls_expiry[i] <= rq.current_time;
                if (due && free_list_insert(ls_start[i], ls_len[i])) begin
                    cnt++;
                    continue;
                end
                if (due) ovfl = 1'b1;
                ls_start[keep] = ls_start[i];
                ls_len[keep] = ls_len[i];
                ls_expiry[keep] = ls_expiry[i];
                keep++;
            end
            ls_count = keep;
            r.status = ovfl ? ffla_pkg::ST_OVFL : ffla_pkg::ST_DONE;
        end else if (rq.req_type == ffla_pkg::REQ_MERGE) begin
            i = 0;
            while (i + 1 < fr_count) begin
                if (fr_start[i] + fr_len[i] == fr_start[i+1]) begin
                    fr_len[i] += fr_len[i+1];
                    free_list_remove(i + 1);
                    cnt++;
                end else begin
                    i++;
                end
            end
        end
        r.event_count = (cnt > 127) ? 7'd127 : cnt[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Driver: bursts of offered requests separated by random gaps.
    int unsigned burst_left;
    int unsigned gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (in_valid && !in_stall) begin
            // The current request is taken; offer the next one or pause.
            void'(request_queue.pop_front());
            if (request_queue.size() > 0 && !hold_sender && burst_left > 0) begin
                in_data <= request_queue[0];
                burst_left <= burst_left - 1;
            end else begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            end
        end else if (!in_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (request_queue.size() > 0 && !hold_sender) begin
                in_valid <= 1'b1;
                in_data <= request_queue[0];
                burst_left <= $urandom_range(0, 20);
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off.
    int unsigned stall_run;
    int unsigned long_count;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
            long_count <= 0;
        end else if (long_count > 0) begin
            long_count <= long_count - 1;
            out_stall <= (long_count > 1);
        end else if (long_stall_req) begin
            long_count <= 600;
            out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            stall_run <= $urandom_range(0, 40);
            out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Monitor: compare each result with the oldest expectation.
    ffla_pkg::t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            result_queue.insert(result_queue.size(), allocator_predict(in_data));
        end
        if (i_rst_n && out_valid && !out_stall) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = result_queue.pop_front();
                if (out_data.status != want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.start_address != want.start_address)
                    report_mismatch("start_address", 32'(out_data.start_address),
                                    32'(want.start_address));
                if (out_data.event_count != want.event_count)
                    report_mismatch("event_count", 32'(out_data.event_count),
                                    32'(want.event_count));
            end
        end
    end

    // Watchdog: counts cycles in which no transfer happens.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic ffla_pkg::t_in_item make_req(ffla_pkg::t_req kind,
                                                    int unsigned bsize,
                                                    logic [31:0] now, int unsigned dur);
        ffla_pkg::t_in_item it;
        it.req_type = kind;
        it.block_size = bsize[ffla_pkg::LEN_W-1:0];
        it.current_time = now;
        it.lease_duration = dur[ffla_pkg::DUR_W-1:0];
        return it;
    endfunction

    // Append one request to the pending queue.
    function automatic void add_request(ffla_pkg::t_req kind, int unsigned bsize,
                                        logic [31:0] now, int unsigned dur);
        request_queue.insert(request_queue.size(), make_req(kind, bsize, now, dur));
    endfunction

    task automatic wait_drained();
        while (request_queue.size() > 0 || result_queue.size() > 0 || in_valid)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_pool(int unsigned size);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size[ffla_pkg::LEN_W-1:0];
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        pool_reinit(size == 0 ? 1 : (size > POOL_MAX ? POOL_MAX : size));
    endtask

    // Random phase: allocations with a moving clock, expiries, merges and unused request codes.
    task automatic random_phase(int unsigned count, int unsigned max_size);
        logic [31:0] now;
        int unsigned pick;
        now = $urandom_range(0, 1000);
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            now += $urandom_range(0, 40);
            if (pick < 55)
                add_request(ffla_pkg::REQ_ALLOC,
                    ($urandom_range(0, 15) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(1, max_size),
                    now, $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 300));
            else if (pick < 80)
                add_request(ffla_pkg::REQ_EXPIRE, $urandom_range(0, 131071),
                    ($urandom_range(0, 20) == 0) ? $urandom() : now,
                    $urandom_range(0, 65535));
            else if (pick < 95)
                add_request(ffla_pkg::REQ_MERGE, $urandom_range(0, 131071),
                    $urandom(), $urandom_range(0, 65535));
            else
                add_request(ffla_pkg::REQ_NONE, $urandom_range(0, 131071),
                    $urandom(), $urandom_range(0, 65535));
        end
    endtask

    initial begin
        mismatches = 0;
        hold_sender = 1'b0;
        long_stall_req = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        pool_reinit(POOL_MAX);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every request kind, saturation and overflow.
        add_request(ffla_pkg::REQ_ALLOC, 0, 32'd0, 0);
        add_request(ffla_pkg::REQ_ALLOC, 131071, 32'd5, 0);
        add_request(ffla_pkg::REQ_ALLOC, 65536, 32'hFFFF_FFFF, 65535);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'hFFFF_FFFE, 0);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'hFFFF_FFFF, 0);
        add_request(ffla_pkg::REQ_ALLOC, 1, 32'd10, 5);
        add_request(ffla_pkg::REQ_ALLOC, 100, 32'd10, 65535);
        add_request(ffla_pkg::REQ_ALLOC, 1, 32'd10, 0);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'd15, 0);
        add_request(ffla_pkg::REQ_MERGE, 0, 32'd0, 0);
        add_request(ffla_pkg::REQ_NONE, 131071, 32'hFFFF_FFFF, 65535);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'hFFFF_FFFF, 0);
        add_request(ffla_pkg::REQ_MERGE, 0, 32'd0, 0);
        wait_drained();

        // Lease table full: 65 single-unit leases, then one of two units.
        for (int unsigned k = 0; k < 65; k++)
            add_request(ffla_pkg::REQ_ALLOC, 1, 32'd100, k);
        add_request(ffla_pkg::REQ_ALLOC, 2, 32'd0, 0);
        // Free every other one so the free list fills and then overflows.
        wait_drained();
        write_pool(200);
        for (int unsigned k = 0; k < 64; k++)
            add_request(ffla_pkg::REQ_ALLOC, 1, 32'd0, (k % 2) ? 10 : 1000);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'd20, 0);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'hFFFF_FFFF, 0);
        add_request(ffla_pkg::REQ_MERGE, 0, 32'd0, 0);
        add_request(ffla_pkg::REQ_EXPIRE, 0, 32'hFFFF_FFFF, 0);
        add_request(ffla_pkg::REQ_MERGE, 0, 32'd0, 0);
        wait_drained();

        // Random phases over several pool sizes, extremes included.
        write_pool(0);
        random_phase(80, 2);
        wait_drained();
        write_pool(131071);
        random_phase(500, 4000);
        // Long receiver hold-off while the sender keeps offering.
        long_stall_req = 1'b1;
        wait (long_count != 0);
        long_stall_req = 1'b0;
        wait_drained();
        write_pool(1000);
        random_phase(500, 60);
        wait_drained();
        write_pool(65536);
        random_phase(400, 3000);
        // The sender pauses until every result has come.
        hold_sender = 1'b1;
        while (in_valid || result_queue.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();
        write_pool(37);
        random_phase(300, 8);
        wait_drained();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
